// File: rtl/core/tps_pkg.sv
// tps_pkg: shared types and constants for the twin prime search unit
// no dependencies
`default_nettype none

package tps_pkg;

  localparam int unsigned QW = 14;

  typedef enum logic [2:0] {
    S_FILL,
    S_SQ,
    S_PRD,
    S_PCHK,
    S_STRIKE,
    S_IDLE,
    S_SCAN
  } state_e;

endpackage

`default_nettype wire

// File: rtl/core/tps_ram.sv
// tps_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module tps_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/twin_prime_sieve_search_unit.sv
// Twin prime search unit. After reset the unit first fills a LIMIT-entry
// primality bitmap and then sieves it (one strike per cycle, for each
// candidate prime p with p*p below LIMIT); busy stays high until that is
// done. A query x is taken when start is high and busy low. The bitmap is
// scanned one bit per cycle through the single read port of the bitmap
// ram, starting at x-1 (at 0 for x = 0), and the scan stops at the first
// upper twin, which it reports, or at the last entry of the bitmap.
// The result is shown with done_o for one cycle and cannot be stalled.
// depends on tps_pkg and tps_ram
`default_nettype none

module twin_prime_sieve_search_unit #(
  parameter int unsigned LIMIT = 16384
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [tps_pkg::QW-1:0] query_value_i,
  output logic      [tps_pkg::QW-1:0] twin_prime_o,
  output logic                        found_o,
  output logic                        done_o
);

  localparam int unsigned AW = $clog2(LIMIT);
  localparam int unsigned CW = (AW + 1 > tps_pkg::QW + 1) ? AW + 1 : tps_pkg::QW + 1;
  localparam int unsigned SW = 2 * AW;
  localparam logic [CW-1:0] LIMIT_C = CW'(LIMIT);
  localparam logic [SW-1:0] LIMIT_S = SW'(LIMIT);
  localparam logic [AW-1:0] LAST = AW'(LIMIT - 1);

  tps_pkg::state_e state_q, state_d;

  logic [AW-1:0]          addr_q, addr_d;
  logic [AW-1:0]          p_q, p_d;
  logic [SW-1:0]          sq_q, sq_d;
  logic [CW-1:0]          m_q, m_d;
  logic                   rd_valid_q, rd_valid_d;
  logic [AW-1:0]          rd_addr_q, rd_addr_d;
  logic                   h1_q, h1_d;
  logic                   h2_q, h2_d;
  logic [1:0]             hcnt_q, hcnt_d;
  logic                   done_q, done_d;
  logic                   found_q, found_d;
  logic [tps_pkg::QW-1:0] prime_q, prime_d;

  logic          we;
  logic [AW-1:0] waddr;
  logic [0:0]    wdata;
  logic [AW-1:0] raddr;
  logic [0:0]    rdata;

  logic          accept;
  logic [CW-1:0] xp1;
  logic [CW-1:0] i0;
  logic          no_room;
  logic          hit;
  logic          at_end;

  tps_ram #(
    .WIDTH(1),
    .DEPTH(LIMIT)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign busy    = (state_q != tps_pkg::S_IDLE);
  assign accept  = start && !busy;
  assign xp1     = CW'(query_value_i) + CW'(1);
  assign i0      = (xp1 < CW'(2)) ? CW'(2) : xp1;
  assign no_room = (i0 >= LIMIT_C);
  assign hit     = (state_q == tps_pkg::S_SCAN) && rd_valid_q && (hcnt_q == 2'd2)
                   && rdata[0] && h2_q;
  assign at_end  = (state_q == tps_pkg::S_SCAN) && rd_valid_q && (rd_addr_q == LAST);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tps_pkg::S_FILL: begin
        if (addr_q == LAST) begin
          state_d = tps_pkg::S_SQ;
        end
      end
      tps_pkg::S_SQ: begin
        state_d = tps_pkg::S_PRD;
      end
      tps_pkg::S_PRD: begin
        state_d = (sq_q < LIMIT_S) ? tps_pkg::S_PCHK : tps_pkg::S_IDLE;
      end
      tps_pkg::S_PCHK: begin
        state_d = rdata[0] ? tps_pkg::S_STRIKE : tps_pkg::S_SQ;
      end
      tps_pkg::S_STRIKE: begin
        if (m_q >= LIMIT_C) begin
          state_d = tps_pkg::S_SQ;
        end
      end
      tps_pkg::S_IDLE: begin
        if (accept && !no_room) begin
          state_d = tps_pkg::S_SCAN;
        end
      end
      tps_pkg::S_SCAN: begin
        if (hit || at_end) begin
          state_d = tps_pkg::S_IDLE;
        end
      end
      default: state_d = tps_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    addr_d     = addr_q;
    p_d        = p_q;
    sq_d       = sq_q;
    m_d        = m_q;
    rd_valid_d = 1'b0;
    rd_addr_d  = rd_addr_q;
    h1_d       = h1_q;
    h2_d       = h2_q;
    hcnt_d     = hcnt_q;
    done_d     = 1'b0;
    found_d    = found_q;
    prime_d    = prime_q;
    we         = 1'b0;
    waddr      = addr_q;
    wdata      = 1'b0;
    raddr      = addr_q;
    unique case (state_q)
      tps_pkg::S_FILL: begin
        we     = 1'b1;
        waddr  = addr_q;
        wdata  = (addr_q >= AW'(2));
        addr_d = addr_q + AW'(1);
      end
      tps_pkg::S_SQ: begin
        sq_d = SW'(p_q) * SW'(p_q);
      end
      tps_pkg::S_PRD: begin
        raddr = p_q;
      end
      tps_pkg::S_PCHK: begin
        if (rdata[0]) begin
          m_d = CW'(sq_q);
        end else begin
          p_d = p_q + AW'(1);
        end
      end
      tps_pkg::S_STRIKE: begin
        if (m_q < LIMIT_C) begin
          we    = 1'b1;
          waddr = m_q[AW-1:0];
          wdata = 1'b0;
          m_d   = m_q + CW'(p_q);
        end else begin
          p_d = p_q + AW'(1);
        end
      end
      tps_pkg::S_IDLE: begin
        if (accept) begin
          if (no_room) begin
            done_d  = 1'b1;
            found_d = 1'b0;
            prime_d = '0;
          end else begin
            addr_d = AW'(i0 - CW'(2));
            hcnt_d = 2'd0;
          end
        end
      end
      tps_pkg::S_SCAN: begin
        raddr      = addr_q;
        rd_valid_d = 1'b1;
        rd_addr_d  = addr_q;
        addr_d     = addr_q + AW'(1);
        if (rd_valid_q) begin
          h1_d = rdata[0];
          h2_d = h1_q;
          if (hcnt_q != 2'd2) begin
            hcnt_d = hcnt_q + 2'd1;
          end
        end
        if (hit) begin
          done_d  = 1'b1;
          found_d = 1'b1;
          prime_d = tps_pkg::QW'(rd_addr_q);
        end else if (at_end) begin
          done_d  = 1'b1;
          found_d = 1'b0;
          prime_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tps_pkg::S_FILL;
      addr_q     <= '0;
      p_q        <= AW'(2);
      rd_valid_q <= 1'b0;
      hcnt_q     <= 2'd0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      addr_q     <= addr_d;
      p_q        <= p_d;
      rd_valid_q <= rd_valid_d;
      hcnt_q     <= hcnt_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q      <= sq_d;
    m_q       <= m_d;
    rd_addr_q <= rd_addr_d;
    h1_q      <= h1_d;
    h2_q      <= h2_d;
    found_q   <= found_d;
    prime_q   <= prime_d;
  end

  assign done_o       = done_q;
  assign found_o      = found_q;
  assign twin_prime_o = prime_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (twin_prime_o == '0))
    else $error("not-found result carries a nonzero value");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted transaction neither scanning nor answered");

  a_scan_one_hist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> (hcnt_q == 2'd2))
    else $error("twin match without two history bits");

endmodule

`default_nettype wire
